### hdl/lru_pr_pkg.sv
// lru_pr_pkg: shared constants and types for the lru page replacement block
// used by lru_pr_cell and lru_page_replacement, no dependencies
`default_nettype none

package lru_pr_pkg;

    localparam int MAX_WAYS  = 16;
    localparam int PAGE_BITS = 31;
    localparam int CFG_W     = 5;
    localparam int HIT_W     = 32;

    localparam logic [CFG_W-1:0] WAYS_RESET = CFG_W'(16);

    typedef struct packed {
        logic active;
        logic done;
        logic hit;
        logic ev_valid;
    } t_tok_ctl;

endpackage

`default_nettype wire

### hdl/lru_pr_cell.sv
// lru_pr_cell: one recency slot of the lru chain and the request stage that visits it
// depends on lru_pr_pkg
`default_nettype none

module lru_pr_cell #(
    parameter int MAX_WAYS  = lru_pr_pkg::MAX_WAYS,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS,
    parameter int IDX       = 0
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire [$clog2(MAX_WAYS+1)-1:0] i_limit,
    input  lru_pr_pkg::t_tok_ctl        i_tok,
    input  wire [PAGE_BITS-1:0]         i_tok_page,
    input  wire [PAGE_BITS-1:0]         i_tok_carry,
    input  wire [PAGE_BITS-1:0]         i_tok_ev_page,
    input  wire                         i_next_valid,
    output lru_pr_pkg::t_tok_ctl        o_tok,
    output logic [PAGE_BITS-1:0]        o_tok_page,
    output logic [PAGE_BITS-1:0]        o_tok_carry,
    output logic [PAGE_BITS-1:0]        o_tok_ev_page,
    output logic                        o_valid
);

    localparam int LIM_W = $clog2(MAX_WAYS + 1);
    localparam logic [LIM_W-1:0] IDX_L = LIM_W'(IDX);

    lru_pr_pkg::t_tok_ctl   r_tok;
    logic [PAGE_BITS-1:0]   r_tok_page;
    logic [PAGE_BITS-1:0]   r_tok_carry;
    logic [PAGE_BITS-1:0]   r_tok_ev_page;
    logic [PAGE_BITS-1:0]   r_page;
    logic                   r_valid;

    logic [PAGE_BITS-1:0]   n_page;
    logic                   n_valid;

    logic                   w_match;
    logic [PAGE_BITS-1:0]   w_post_page;
    logic                   w_post_valid;
    logic                   w_done_out;
    logic                   w_hit_out;
    logic [PAGE_BITS-1:0]   w_carry_out;
    logic                   w_last;
    logic                   w_evict;

    always_comb begin
        w_match = r_valid && (r_page == r_tok_page);
        if (!r_tok.done) begin
            w_post_page  = r_tok_carry;
            w_post_valid = 1'b1;
            if (w_match) begin
                w_done_out  = 1'b1;
                w_hit_out   = 1'b1;
                w_carry_out = r_tok_carry;
            end else begin
                w_done_out  = !r_valid;
                w_hit_out   = 1'b0;
                w_carry_out = r_page;
            end
        end else begin
            w_post_page  = r_page;
            w_post_valid = r_valid;
            w_done_out   = 1'b1;
            w_hit_out    = 1'b0;
            w_carry_out  = r_tok_carry;
        end
        // last resident slot after this request, trimmed when past the limit
        w_last  = w_post_valid && w_done_out && !i_next_valid;
        w_evict = r_tok.active && w_last && (IDX_L >= i_limit);

        n_page  = r_tok.active ? w_post_page : r_page;
        n_valid = r_tok.active ? (w_post_valid && !w_evict) : r_valid;
    end

    always_comb begin
        o_tok.active   = r_tok.active;
        o_tok.done     = w_done_out;
        o_tok.hit      = r_tok.hit | w_hit_out;
        o_tok.ev_valid = r_tok.ev_valid | w_evict;
        o_tok_page     = r_tok_page;
        o_tok_carry    = w_carry_out;
        o_tok_ev_page  = w_evict ? w_post_page : r_tok_ev_page;
        o_valid        = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tok   <= i_tok;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_page    <= i_tok_page;
        r_tok_carry   <= i_tok_carry;
        r_tok_ev_page <= i_tok_ev_page;
        r_page        <= n_page;
    end

endmodule

`default_nettype wire

### hdl/lru_page_replacement.sv
// lru_page_replacement: fully associative lru replacement over a chain of recency cells
// depends on lru_pr_pkg and lru_pr_cell
// a request walks the cell chain one cell per cycle and no new request is accepted
// until it has left the chain and the skid slot is empty; a finished result
//   waits in an output register with one skid slot
// reset: store empty, hit count zero, ways_in_use back to 16
`default_nettype none

module lru_page_replacement #(
    parameter int MAX_WAYS  = lru_pr_pkg::MAX_WAYS,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [lru_pr_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire [PAGE_BITS-1:0]             i_page_number,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic                            o_hit,
    output logic                            o_evicted_valid,
    output logic [PAGE_BITS-1:0]            o_evicted_page,
    output logic [lru_pr_pkg::HIT_W-1:0]    o_hit_total
);

    localparam int LIM_W = $clog2(MAX_WAYS + 1);
    localparam int CFG_W = lru_pr_pkg::CFG_W;
    localparam int HIT_W = lru_pr_pkg::HIT_W;
    localparam int CW    = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    logic [CFG_W-1:0]       r_ways;
    logic                   r_busy;
    logic [HIT_W-1:0]       r_hit_cnt;
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic                   r_out_ev_valid;
    logic [PAGE_BITS-1:0]   r_out_ev_page;
    logic [HIT_W-1:0]       r_out_total;
    logic                   r_skid_valid;
    logic                   r_skid_hit;
    logic                   r_skid_ev_valid;
    logic [PAGE_BITS-1:0]   r_skid_ev_page;
    logic [HIT_W-1:0]       r_skid_total;

    logic                   n_busy;
    logic [HIT_W-1:0]       n_hit_cnt;
    logic                   n_out_valid;
    logic                   n_out_hit;
    logic                   n_out_ev_valid;
    logic [PAGE_BITS-1:0]   n_out_ev_page;
    logic [HIT_W-1:0]       n_out_total;
    logic                   n_skid_valid;
    logic                   n_skid_hit;
    logic                   n_skid_ev_valid;
    logic [PAGE_BITS-1:0]   n_skid_ev_page;
    logic [HIT_W-1:0]       n_skid_total;

    logic [CW-1:0]          w_ways_ext;
    logic [CW-1:0]          w_lim_ext;
    logic [LIM_W-1:0]       w_limit;
    logic                   w_accept;
    logic                   w_take;
    logic                   w_exit;
    logic                   w_x_hit;
    logic                   w_x_ev_valid;
    logic [PAGE_BITS-1:0]   w_x_ev_page;
    logic [HIT_W-1:0]       w_x_total;

    lru_pr_pkg::t_tok_ctl   w_tok     [MAX_WAYS+1];
    logic [PAGE_BITS-1:0]   w_tok_page [MAX_WAYS+1];
    logic [PAGE_BITS-1:0]   w_tok_carry [MAX_WAYS+1];
    logic [PAGE_BITS-1:0]   w_tok_ev_page [MAX_WAYS+1];
    logic                   w_cell_valid [MAX_WAYS+1];

    // effective way limit: zero acts as one, above the built depth acts as the depth
    always_comb begin
        w_ways_ext = CW'(r_ways);
        if (w_ways_ext == '0) begin
            w_lim_ext = CW'(1);
        end else if (w_ways_ext > CW'(MAX_WAYS)) begin
            w_lim_ext = CW'(MAX_WAYS);
        end else begin
            w_lim_ext = w_ways_ext;
        end
        w_limit = w_lim_ext[LIM_W-1:0];
    end

    assign o_stall  = r_busy || r_skid_valid;
    assign w_accept = i_valid && !o_stall;

    assign w_tok[0].active        = w_accept;
    assign w_tok[0].done          = 1'b0;
    assign w_tok[0].hit           = 1'b0;
    assign w_tok[0].ev_valid      = 1'b0;
    assign w_tok_page[0]          = i_page_number;
    assign w_tok_carry[0]         = i_page_number;
    assign w_tok_ev_page[0]       = '0;
    assign w_cell_valid[MAX_WAYS] = 1'b0;

    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_cell
        lru_pr_cell #(
            .MAX_WAYS  (MAX_WAYS),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_limit       (w_limit),
            .i_tok         (w_tok[g]),
            .i_tok_page    (w_tok_page[g]),
            .i_tok_carry   (w_tok_carry[g]),
            .i_tok_ev_page (w_tok_ev_page[g]),
            .i_next_valid  (w_cell_valid[g+1]),
            .o_tok         (w_tok[g+1]),
            .o_tok_page    (w_tok_page[g+1]),
            .o_tok_carry   (w_tok_carry[g+1]),
            .o_tok_ev_page (w_tok_ev_page[g+1]),
            .o_valid       (w_cell_valid[g])
        );
    end

    // a carry still pending past the last cell is the page pushed out of a full store
    always_comb begin
        w_exit       = w_tok[MAX_WAYS].active;
        w_x_hit      = w_tok[MAX_WAYS].hit;
        w_x_ev_valid = w_tok[MAX_WAYS].ev_valid || !w_tok[MAX_WAYS].done;
        w_x_ev_page  = w_tok[MAX_WAYS].done ? w_tok_ev_page[MAX_WAYS]
                                             : w_tok_carry[MAX_WAYS];
        w_x_total    = r_hit_cnt + HIT_W'(w_x_hit);
        w_take       = r_out_valid && !i_stall;
    end

    always_comb begin
        n_busy          = r_busy;
        n_hit_cnt       = r_hit_cnt;
        n_out_valid     = r_out_valid;
        n_out_hit       = r_out_hit;
        n_out_ev_valid  = r_out_ev_valid;
        n_out_ev_page   = r_out_ev_page;
        n_out_total     = r_out_total;
        n_skid_valid    = r_skid_valid;
        n_skid_hit      = r_skid_hit;
        n_skid_ev_valid = r_skid_ev_valid;
        n_skid_ev_page  = r_skid_ev_page;
        n_skid_total    = r_skid_total;

        if (w_accept) begin
            n_busy = 1'b1;
        end
        if (w_take) begin
            n_out_valid = 1'b0;
        end
        if (w_take && r_skid_valid) begin
            n_out_valid    = 1'b1;
            n_out_hit      = r_skid_hit;
            n_out_ev_valid = r_skid_ev_valid;
            n_out_ev_page  = r_skid_ev_page;
            n_out_total    = r_skid_total;
            n_skid_valid   = 1'b0;
        end
        if (w_exit) begin
            n_busy    = 1'b0;
            n_hit_cnt = w_x_total;
            if ((!r_out_valid || w_take) && !r_skid_valid) begin
                n_out_valid    = 1'b1;
                n_out_hit      = w_x_hit;
                n_out_ev_valid = w_x_ev_valid;
                n_out_ev_page  = w_x_ev_page;
                n_out_total    = w_x_total;
            end else begin
                n_skid_valid    = 1'b1;
                n_skid_hit      = w_x_hit;
                n_skid_ev_valid = w_x_ev_valid;
                n_skid_ev_page  = w_x_ev_page;
                n_skid_total    = w_x_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways       <= lru_pr_pkg::WAYS_RESET;
            r_busy       <= 1'b0;
            r_hit_cnt    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ways <= i_cfg_data;
            end
            r_busy       <= n_busy;
            r_hit_cnt    <= n_hit_cnt;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit       <= n_out_hit;
        r_out_ev_valid  <= n_out_ev_valid;
        r_out_ev_page   <= n_out_ev_page;
        r_out_total     <= n_out_total;
        r_skid_hit      <= n_skid_hit;
        r_skid_ev_valid <= n_skid_ev_valid;
        r_skid_ev_page  <= n_skid_ev_page;
        r_skid_total    <= n_skid_total;
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_hit_total     = r_out_total;

endmodule

`default_nettype wire
